FILE: hdl/tree_lowest_common_ancestor_assert.svh
// assertion macros for the tree ancestor block
`ifndef TREE_LOWEST_COMMON_ANCESTOR_ASSERT_SVH
`define TREE_LOWEST_COMMON_ANCESTOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TLCA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tlca_pkg.sv
// types and constants shared by the tree ancestor block
`timescale 1ns / 1ps

package tlca_pkg;

    localparam int unsigned MAX_NODES_DEF = 65536;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_EDGE   = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_NOT_BUILT = 2'd1;
    localparam logic [1:0] ERR_BAD_NODE  = 2'd2;
    localparam logic [1:0] ERR_EXCESS    = 2'd3;

    localparam logic [15:0] ROOT_NODE      = 16'd1;
    localparam logic [15:0] NODE_COUNT_RST = 16'd1;
    localparam logic        REG_NODE_COUNT = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EMIT,
        ST_CLR,
        ST_EG_RD,
        ST_EG_A,
        ST_EG_AW,
        ST_EG_B,
        ST_EG_BW,
        ST_PF_RD,
        ST_PF_WR,
        ST_BF_INIT,
        ST_BF_Q,
        ST_BF_P,
        ST_BF_S,
        ST_BF_K,
        ST_BF_C,
        ST_BF_W,
        ST_QY_A,
        ST_QY_B,
        ST_QY_C,
        ST_QY_L,
        ST_QY_W
    } state_t;

endpackage

FILE: hdl/tlca_req_if.sv
// request channel: request type and two node numbers
`timescale 1ns / 1ps

interface tlca_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] node_a;
    logic [15:0] node_b;

    modport source (output valid, req_type, node_a, node_b, input ready);
    modport sink (input valid, req_type, node_a, node_b, output ready);
endinterface

FILE: hdl/tlca_rsp_if.sv
// result channel: ancestor node and error code
`timescale 1ns / 1ps

interface tlca_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] ancestor;
    logic [1:0]  error_code;

    modport source (output valid, ancestor, error_code, input ready);
    modport sink (input valid, ancestor, error_code, output ready);
endinterface

FILE: hdl/tree_lowest_common_ancestor.sv
// tree ancestor block: edge collection, bfs build and climbing queries
// usage:
//   req carries words of type clear, edge or query; rsp returns one word per
//   query or rejected edge. node_count is to be written over the apb port only
//   while idle, which the block does not enforce; the write empties the tree.
//   once node_count-1 edges are held the block builds parent and depth tables
//   (also on a query if enough edges are held but the tree is still unbuilt).
//   rejected edges and early queries go from the emit state to the result
//   register; a query on a built tree climbs one step per read of the node
//   memory, and the build is paced by the single read port of each memory in
//   the degree, prefix and search passes.
//   one word is worked on at a time; req.ready is high only when idle.
//   the result register holds a word while rsp stalls; the next word is still
//   taken and its result waits in the block until the register frees.
//   reset empties the tree and sets node_count to 1; memories need no clearing
//   pass, the build clears what it uses.
`timescale 1ns / 1ps
`include "tree_lowest_common_ancestor_assert.svh"

module tree_lowest_common_ancestor #(
    parameter int unsigned MAX_NODES = tlca_pkg::MAX_NODES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    tlca_req_if.sink         req,
    tlca_rsp_if.source       rsp,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int NW     = $clog2(MAX_NODES);
    localparam int AW     = NW + 1;
    localparam int NODE_W = NW + 17;
    localparam logic [16:0] CAP = (MAX_NODES - 1 > 65535) ? 17'd65535 : 17'(MAX_NODES - 1);

    // memories
    logic [31:0]       edge_mem  [MAX_NODES];
    logic [AW-1:0]     cnt_mem   [MAX_NODES];
    logic [2*AW-1:0]   span_mem  [MAX_NODES];
    logic [NW-1:0]     adj_mem   [2*MAX_NODES];
    logic [NODE_W-1:0] node_mem  [MAX_NODES];
    logic [NW-1:0]     queue_mem [MAX_NODES];

    logic              e_we;
    logic [NW-1:0]     e_waddr, e_raddr;
    logic [31:0]       e_wdata, e_rd_reg;
    logic              c_we;
    logic [NW-1:0]     c_waddr, c_raddr;
    logic [AW-1:0]     c_wdata, c_rd_reg;
    logic              s_we;
    logic [NW-1:0]     s_waddr, s_raddr;
    logic [2*AW-1:0]   s_wdata, s_rd_reg;
    logic              a_we;
    logic [AW-1:0]     a_waddr, a_raddr;
    logic [NW-1:0]     a_wdata, a_rd_reg;
    logic              n_we;
    logic [NW-1:0]     n_waddr, n_raddr;
    logic [NODE_W-1:0] n_wdata, n_rd_reg;
    logic              q_we;
    logic [NW-1:0]     q_waddr, q_raddr;
    logic [NW-1:0]     q_wdata, q_rd_reg;

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            edge_mem[e_waddr] <= e_wdata;
        end
        e_rd_reg <= edge_mem[e_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            cnt_mem[c_waddr] <= c_wdata;
        end
        c_rd_reg <= cnt_mem[c_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            span_mem[s_waddr] <= s_wdata;
        end
        s_rd_reg <= span_mem[s_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            adj_mem[a_waddr] <= a_wdata;
        end
        a_rd_reg <= adj_mem[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (n_we)
        begin
            node_mem[n_waddr] <= n_wdata;
        end
        n_rd_reg <= node_mem[n_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[q_waddr] <= q_wdata;
        end
        q_rd_reg <= queue_mem[q_raddr];
    end

    // node word fields
    logic          nd_reached;
    logic [15:0]   nd_depth;
    logic [NW-1:0] nd_parent;
    assign nd_reached = n_rd_reg[NODE_W-1];
    assign nd_depth   = n_rd_reg[NW+15:NW];
    assign nd_parent  = n_rd_reg[NW-1:0];

    // registers
    tlca_pkg::state_t state_reg, state_next;
    logic [15:0]   node_count_reg, node_count_next;
    logic [15:0]   edge_total_reg, edge_total_next;
    logic          tree_ready_reg, tree_ready_next;
    logic          qpend_reg, qpend_next;
    logic          pass_reg, pass_next;
    logic [15:0]   cnt_reg, cnt_next;
    logic [AW-1:0] run_reg, run_next;
    logic [NW-1:0] ea_reg, ea_next, eb_reg, eb_next;
    logic [15:0]   head_reg, head_next, tail_reg, tail_next;
    logic [NW-1:0] p_reg, p_next, c_reg, c_next;
    logic [15:0]   pd_reg, pd_next;
    logic [AW-1:0] k_reg, k_next, kend_reg, kend_next;
    logic [NW-1:0] qa_reg, qa_next, qb_reg, qb_next;
    logic [NW-1:0] pa_reg, pa_next, pb_reg, pb_next;
    logic [15:0]   da_reg, da_next, db_reg, db_next;
    logic          oka_reg, oka_next, okb_reg, okb_next;
    logic          ra_reg, ra_next, side_reg, side_next;
    logic [15:0]   res_anc_reg, res_anc_next;
    logic [1:0]    res_err_reg, res_err_next;
    logic          out_valid_reg, out_valid_next;
    logic [15:0]   out_anc_reg, out_anc_next;
    logic [1:0]    out_err_reg, out_err_next;

    // effective node count and edges needed
    logic [15:0] nc0, eff, need;
    logic        cfg_wr;
    assign nc0  = (node_count_reg == 16'd0) ? 16'd1 : node_count_reg;
    assign eff  = ({1'b0, nc0} > CAP) ? CAP[15:0] : nc0;
    assign need = eff - 16'd1;

    function automatic logic node_ok(input logic [15:0] v, input logic [15:0] lim);
        node_ok = (v != 16'd0) && (v <= lim);
    endfunction

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == tlca_pkg::REG_NODE_COUNT);
    assign prdata = (paddr[2] == tlca_pkg::REG_NODE_COUNT) ? {16'd0, node_count_reg} : 32'd0;

    assign req.ready      = (state_reg == tlca_pkg::ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.ancestor   = out_anc_reg;
    assign rsp.error_code = out_err_reg;

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        edge_total_next = edge_total_reg;
        tree_ready_next = tree_ready_reg;
        qpend_next      = qpend_reg;
        pass_next       = pass_reg;
        cnt_next        = cnt_reg;
        run_next        = run_reg;
        ea_next         = ea_reg;
        eb_next         = eb_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        p_next          = p_reg;
        c_next          = c_reg;
        pd_next         = pd_reg;
        k_next          = k_reg;
        kend_next       = kend_reg;
        qa_next         = qa_reg;
        qb_next         = qb_reg;
        pa_next         = pa_reg;
        pb_next         = pb_reg;
        da_next         = da_reg;
        db_next         = db_reg;
        oka_next        = oka_reg;
        okb_next        = okb_reg;
        ra_next         = ra_reg;
        side_next       = side_reg;
        res_anc_next    = res_anc_reg;
        res_err_next    = res_err_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_anc_next    = out_anc_reg;
        out_err_next    = out_err_reg;

        e_we = 1'b0; e_waddr = '0; e_wdata = '0; e_raddr = '0;
        c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_raddr = '0;
        s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = '0;
        a_we = 1'b0; a_waddr = '0; a_wdata = '0; a_raddr = '0;
        n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;

        if (cfg_wr)
        begin
            node_count_next = pwdata[15:0];
            edge_total_next = 16'd0;
            tree_ready_next = 1'b0;
        end

        unique case (state_reg)
            tlca_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    qa_next  = NW'(req.node_a);
                    qb_next  = NW'(req.node_b);
                    oka_next = node_ok(req.node_a, eff);
                    okb_next = node_ok(req.node_b, eff);
                    res_anc_next = 16'd0;
                    priority case (req.req_type)
                        tlca_pkg::REQ_CLEAR:
                        begin
                            edge_total_next = 16'd0;
                            tree_ready_next = 1'b0;
                        end
                        tlca_pkg::REQ_EDGE:
                        begin
                            if (tree_ready_reg || edge_total_reg >= need)
                            begin
                                res_err_next = tlca_pkg::ERR_EXCESS;
                                state_next   = tlca_pkg::ST_EMIT;
                            end
                            else if (!node_ok(req.node_a, eff) || !node_ok(req.node_b, eff))
                            begin
                                res_err_next = tlca_pkg::ERR_BAD_NODE;
                                state_next   = tlca_pkg::ST_EMIT;
                            end
                            else
                            begin
                                e_we            = 1'b1;
                                e_waddr         = NW'(edge_total_reg);
                                e_wdata         = {req.node_a, req.node_b};
                                edge_total_next = edge_total_reg + 16'd1;
                                if (edge_total_reg + 16'd1 >= need)
                                begin
                                    qpend_next = 1'b0;
                                    cnt_next   = 16'd1;
                                    state_next = tlca_pkg::ST_CLR;
                                end
                            end
                        end
                        tlca_pkg::REQ_QUERY:
                        begin
                            if (!tree_ready_reg && edge_total_reg >= need)
                            begin
                                qpend_next = 1'b1;
                                cnt_next   = 16'd1;
                                state_next = tlca_pkg::ST_CLR;
                            end
                            else if (!tree_ready_reg)
                            begin
                                res_err_next = tlca_pkg::ERR_NOT_BUILT;
                                state_next   = tlca_pkg::ST_EMIT;
                            end
                            else
                            begin
                                state_next = tlca_pkg::ST_QY_A;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            tlca_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_anc_next   = res_anc_reg;
                    out_err_next   = res_err_reg;
                    state_next     = tlca_pkg::ST_IDLE;
                end
            end

            // clear degree counts and node words for nodes 1..n
            tlca_pkg::ST_CLR:
            begin
                c_we    = 1'b1;
                c_waddr = NW'(cnt_reg);
                n_we    = 1'b1;
                n_waddr = NW'(cnt_reg);
                if (cnt_reg == eff)
                begin
                    pass_next = 1'b0;
                    if (edge_total_reg == 16'd0)
                    begin
                        cnt_next   = 16'd1;
                        run_next   = '0;
                        state_next = tlca_pkg::ST_PF_RD;
                    end
                    else
                    begin
                        cnt_next   = 16'd0;
                        state_next = tlca_pkg::ST_EG_RD;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 16'd1;
                end
            end

            // edge walk: degree count on the first pass, list fill on the second
            tlca_pkg::ST_EG_RD:
            begin
                e_raddr    = NW'(cnt_reg);
                state_next = tlca_pkg::ST_EG_A;
            end
            tlca_pkg::ST_EG_A:
            begin
                ea_next    = NW'(e_rd_reg[31:16]);
                eb_next    = NW'(e_rd_reg[15:0]);
                c_raddr    = NW'(e_rd_reg[31:16]);
                state_next = tlca_pkg::ST_EG_AW;
            end
            tlca_pkg::ST_EG_AW:
            begin
                c_we    = 1'b1;
                c_waddr = ea_reg;
                c_wdata = c_rd_reg + AW'(1);
                a_we    = pass_reg;
                a_waddr = c_rd_reg;
                a_wdata = eb_reg;
                state_next = tlca_pkg::ST_EG_B;
            end
            tlca_pkg::ST_EG_B:
            begin
                c_raddr    = eb_reg;
                state_next = tlca_pkg::ST_EG_BW;
            end
            tlca_pkg::ST_EG_BW:
            begin
                c_we    = 1'b1;
                c_waddr = eb_reg;
                c_wdata = c_rd_reg + AW'(1);
                a_we    = pass_reg;
                a_waddr = c_rd_reg;
                a_wdata = ea_reg;
                if (cnt_reg + 16'd1 == edge_total_reg)
                begin
                    if (pass_reg)
                    begin
                        state_next = tlca_pkg::ST_BF_INIT;
                    end
                    else
                    begin
                        cnt_next   = 16'd1;
                        run_next   = '0;
                        state_next = tlca_pkg::ST_PF_RD;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + 16'd1;
                    state_next = tlca_pkg::ST_EG_RD;
                end
            end

            // prefix sum of degrees into list spans; count memory becomes fill pointer
            tlca_pkg::ST_PF_RD:
            begin
                c_raddr    = NW'(cnt_reg);
                state_next = tlca_pkg::ST_PF_WR;
            end
            tlca_pkg::ST_PF_WR:
            begin
                c_we     = 1'b1;
                c_waddr  = NW'(cnt_reg);
                c_wdata  = run_reg;
                s_we     = 1'b1;
                s_waddr  = NW'(cnt_reg);
                s_wdata  = {run_reg, run_reg + c_rd_reg};
                run_next = run_reg + c_rd_reg;
                if (cnt_reg == eff)
                begin
                    pass_next = 1'b1;
                    cnt_next  = 16'd0;
                    state_next = (edge_total_reg == 16'd0) ? tlca_pkg::ST_BF_INIT
                                                           : tlca_pkg::ST_EG_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg + 16'd1;
                    state_next = tlca_pkg::ST_PF_RD;
                end
            end

            // breadth-first search from the root
            tlca_pkg::ST_BF_INIT:
            begin
                n_we       = 1'b1;
                n_waddr    = NW'(tlca_pkg::ROOT_NODE);
                n_wdata    = {1'b1, 16'd0, NW'(tlca_pkg::ROOT_NODE)};
                q_we       = 1'b1;
                q_waddr    = '0;
                q_wdata    = NW'(tlca_pkg::ROOT_NODE);
                head_next  = 16'd0;
                tail_next  = 16'd1;
                state_next = tlca_pkg::ST_BF_Q;
            end
            tlca_pkg::ST_BF_Q:
            begin
                if (head_reg == tail_reg)
                begin
                    tree_ready_next = 1'b1;
                    state_next = qpend_reg ? tlca_pkg::ST_QY_A : tlca_pkg::ST_IDLE;
                end
                else
                begin
                    q_raddr    = NW'(head_reg);
                    state_next = tlca_pkg::ST_BF_P;
                end
            end
            tlca_pkg::ST_BF_P:
            begin
                p_next     = q_rd_reg;
                s_raddr    = q_rd_reg;
                n_raddr    = q_rd_reg;
                state_next = tlca_pkg::ST_BF_S;
            end
            tlca_pkg::ST_BF_S:
            begin
                k_next     = s_rd_reg[2*AW-1:AW];
                kend_next  = s_rd_reg[AW-1:0];
                pd_next    = nd_depth;
                state_next = tlca_pkg::ST_BF_K;
            end
            tlca_pkg::ST_BF_K:
            begin
                if (k_reg == kend_reg)
                begin
                    head_next  = head_reg + 16'd1;
                    state_next = tlca_pkg::ST_BF_Q;
                end
                else
                begin
                    a_raddr    = k_reg;
                    state_next = tlca_pkg::ST_BF_C;
                end
            end
            tlca_pkg::ST_BF_C:
            begin
                c_next     = a_rd_reg;
                n_raddr    = a_rd_reg;
                state_next = tlca_pkg::ST_BF_W;
            end
            tlca_pkg::ST_BF_W:
            begin
                if (!nd_reached)
                begin
                    n_we      = 1'b1;
                    n_waddr   = c_reg;
                    n_wdata   = {1'b1, pd_reg + 16'd1, p_reg};
                    q_we      = 1'b1;
                    q_waddr   = NW'(tail_reg);
                    q_wdata   = c_reg;
                    tail_next = tail_reg + 16'd1;
                end
                k_next     = k_reg + AW'(1);
                state_next = tlca_pkg::ST_BF_K;
            end

            // query: fetch both nodes, then climb one step per node read
            tlca_pkg::ST_QY_A:
            begin
                res_anc_next = 16'd0;
                if (!oka_reg || !okb_reg)
                begin
                    res_err_next = tlca_pkg::ERR_BAD_NODE;
                    state_next   = tlca_pkg::ST_EMIT;
                end
                else
                begin
                    n_raddr    = qa_reg;
                    state_next = tlca_pkg::ST_QY_B;
                end
            end
            tlca_pkg::ST_QY_B:
            begin
                ra_next    = nd_reached;
                da_next    = nd_depth;
                pa_next    = nd_parent;
                n_raddr    = qb_reg;
                state_next = tlca_pkg::ST_QY_C;
            end
            tlca_pkg::ST_QY_C:
            begin
                db_next = nd_depth;
                pb_next = nd_parent;
                if (!ra_reg || !nd_reached)
                begin
                    res_err_next = tlca_pkg::ERR_BAD_NODE;
                    state_next   = tlca_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = tlca_pkg::ST_QY_L;
                end
            end
            tlca_pkg::ST_QY_L:
            begin
                // at equal depth a climbs first, b follows on the depth mismatch
                if (db_reg > da_reg)
                begin
                    side_next  = 1'b1;
                    n_raddr    = pb_reg;
                    state_next = tlca_pkg::ST_QY_W;
                end
                else if (da_reg > db_reg || qa_reg != qb_reg)
                begin
                    side_next  = 1'b0;
                    n_raddr    = pa_reg;
                    state_next = tlca_pkg::ST_QY_W;
                end
                else
                begin
                    res_anc_next = 16'(qa_reg);
                    res_err_next = tlca_pkg::ERR_OK;
                    state_next   = tlca_pkg::ST_EMIT;
                end
            end
            tlca_pkg::ST_QY_W:
            begin
                if (side_reg)
                begin
                    qb_next = pb_reg;
                    db_next = nd_depth;
                    pb_next = nd_parent;
                end
                else
                begin
                    qa_next = pa_reg;
                    da_next = nd_depth;
                    pa_next = nd_parent;
                end
                state_next = tlca_pkg::ST_QY_L;
            end
            default:
            begin
                state_next = tlca_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tlca_pkg::ST_IDLE;
            node_count_reg <= tlca_pkg::NODE_COUNT_RST;
            edge_total_reg <= 16'd0;
            tree_ready_reg <= 1'b0;
            qpend_reg      <= 1'b0;
            pass_reg       <= 1'b0;
            cnt_reg        <= 16'd0;
            head_reg       <= 16'd0;
            tail_reg       <= 16'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            edge_total_reg <= edge_total_next;
            tree_ready_reg <= tree_ready_next;
            qpend_reg      <= qpend_next;
            pass_reg       <= pass_next;
            cnt_reg        <= cnt_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg     <= run_next;
        ea_reg      <= ea_next;
        eb_reg      <= eb_next;
        p_reg       <= p_next;
        c_reg       <= c_next;
        pd_reg      <= pd_next;
        k_reg       <= k_next;
        kend_reg    <= kend_next;
        qa_reg      <= qa_next;
        qb_reg      <= qb_next;
        pa_reg      <= pa_next;
        pb_reg      <= pb_next;
        da_reg      <= da_next;
        db_reg      <= db_next;
        oka_reg     <= oka_next;
        okb_reg     <= okb_next;
        ra_reg      <= ra_next;
        side_reg    <= side_next;
        res_anc_reg <= res_anc_next;
        res_err_reg <= res_err_next;
        out_anc_reg <= out_anc_next;
        out_err_reg <= out_err_next;
    end

    `TLCA_ASSERT_NOW(a_err_zero_anc, out_valid_reg && (out_err_reg != tlca_pkg::ERR_OK), out_anc_reg == 16'd0, "error word carries a nonzero ancestor")
    `TLCA_ASSERT_NOW(a_ready_has_edges, tree_ready_reg, edge_total_reg >= need, "tree marked built with too few edges")
    `TLCA_ASSERT_NOW(a_queue_order, 1'b1, head_reg <= tail_reg, "search queue head passed its tail")
    `TLCA_ASSERT_NEXT(a_emit_free, (state_reg == tlca_pkg::ST_EMIT) && !out_valid_reg, out_valid_reg && (state_reg == tlca_pkg::ST_IDLE), "pending result not moved to the output register")

endmodule
